[hdl/art_pkg.sv]
// shared constants for the ack range tracker: field widths, opcodes and status codes
`default_nettype none
package art_pkg;

    localparam int MAX_RANGES_DEF  = 32;
    localparam int NUMBER_BITS_DEF = 62;

    localparam int OP_W  = 3;
    localparam int ST_W  = 4;
    localparam int EXT_W = 6;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_PRUNE  = 3'd1;
    localparam logic [OP_W-1:0] OP_LOSS   = 3'd2;
    localparam logic [OP_W-1:0] OP_GEN    = 3'd3;
    localparam logic [OP_W-1:0] OP_DROP   = 3'd4;

    localparam logic [ST_W-1:0] ST_INSERTED = 4'd0;
    localparam logic [ST_W-1:0] ST_DUP      = 4'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 4'd2;
    localparam logic [ST_W-1:0] ST_NOT_LOST = 4'd3;
    localparam logic [ST_W-1:0] ST_LOST     = 4'd4;
    localparam logic [ST_W-1:0] ST_ACK_HEAD = 4'd5;
    localparam logic [ST_W-1:0] ST_ACK_RNG  = 4'd6;
    localparam logic [ST_W-1:0] ST_NO_ACK   = 4'd7;
    localparam logic [ST_W-1:0] ST_DONE     = 4'd8;

endpackage
`default_nettype wire

[hdl/ack_range_tracker.sv]
// ack range tracker top level: range table in a synchronous memory and its sequencer
//
//  channel | dir | tdata (low bit up)                              | tuser  | tlast
//  s_      | in  | packet_number, ignore_below, now_time,          | opcode | -
//          |     | send_request, alarm_time, largest_seen_time     |        |
//  m_      | out | highest_acked, range_length, gap_value,         | status | last
//          |     | ack_delay, extra_ranges                         |        |
//
// one item at a time; every table access goes through the single read port of
// the range memory; each entry visited is read (address), then evaluated
// insert: each range scanned is read, then evaluated; each entry moved is read, then written; S_PUT writes a new range
// generate: each range reported is read, evaluated, then held until the output handshake
// sync active-low reset clears state, count, threshold, dropped/head/more/valid flags only
// the output register holds a result until the sink takes it; no input is taken meanwhile
`default_nettype none
module ack_range_tracker #(
    parameter int MAX_RANGES  = art_pkg::MAX_RANGES_DEF,
    parameter int NUMBER_BITS = art_pkg::NUMBER_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // packet_number, ignore_below, now_time, send_request, alarm_time, largest_seen_time
    input  wire logic [((5*NUMBER_BITS+1+7)/8)*8-1:0] i_s_tdata,
    // opcode
    input  wire logic [art_pkg::OP_W-1:0]      i_s_tuser,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // highest_acked, range_length, gap_value, ack_delay, extra_ranges
    output logic [((4*NUMBER_BITS+art_pkg::EXT_W+7)/8)*8-1:0] o_m_tdata,
    // status
    output logic [art_pkg::ST_W-1:0]           o_m_tuser,
    output logic                               o_m_tlast
);
    import art_pkg::*;

    localparam int NB   = NUMBER_BITS;
    localparam int TW   = $clog2(MAX_RANGES + 1);
    localparam int AW   = $clog2(MAX_RANGES);
    localparam int OUTW = ((4*NUMBER_BITS + EXT_W + 7) / 8) * 8;
    localparam logic [NB-1:0] MASK = '1;

    typedef struct packed {
        logic [NB-1:0] lo;
        logic [NB-1:0] hi;
    } t_ent;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [NB-1:0]    la;
        logic [NB-1:0]    len;
        logic [NB-1:0]    gap;
        logic [NB-1:0]    dly;
        logic [EXT_W-1:0] ext;
        logic             last;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE, S_INS_RD, S_INS_EV, S_MRG_RD, S_MRG_EV, S_SHD_RD, S_SHD_WR,
        S_SHU_RD, S_SHU_WR, S_PUT, S_PR_RD, S_PR_EV, S_LS_TRD, S_LS_TEV,
        S_LS_RD, S_LS_EV, S_GEN_RD, S_GEN_EV, S_OUT
    } t_state;

    // input fields
    logic [NB-1:0] s_pn, s_ib, s_now, s_alarm, s_seen;
    logic          s_req;
    assign s_pn    = i_s_tdata[NB-1:0];
    assign s_ib    = i_s_tdata[2*NB-1:NB];
    assign s_now   = i_s_tdata[3*NB-1:2*NB];
    assign s_req   = i_s_tdata[3*NB];
    assign s_alarm = i_s_tdata[4*NB:3*NB+1];
    assign s_seen  = i_s_tdata[5*NB:4*NB+1];

    t_state          r_state, n_state;
    logic [TW-1:0]   r_i, n_i, r_j, n_j, r_total, n_total;
    logic [AW-1:0]   r_addr, n_addr;
    logic [NB-1:0]   r_num, n_num, r_thr, n_thr, r_delay, n_delay;
    logic            r_dropped, n_dropped, r_head, n_head, r_more, n_more;
    logic            r_ov, n_ov;
    logic [OP_W-1:0] r_op, n_op;
    t_ent            r_prev, n_prev, r_cur, n_cur;
    t_out            r_out, n_out;

    // range memory, one read and one write port
    t_ent            r_mem [MAX_RANGES];
    t_ent            r_rd;
    logic            w_we;
    logic [AW-1:0]   w_wa;
    t_ent            w_wd;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd <= r_mem[r_addr];
    end

    function automatic t_out f_single(input logic [ST_W-1:0] st);
        t_out o;
        o        = '0;
        o.status = st;
        o.last   = 1'b1;
        return o;
    endfunction

    // deferred actions shared between states
    logic            do_place, do_remove, do_rfin, do_emit;
    logic [TW-1:0]   place_k, rem_k;
    logic [ST_W-1:0] emit_st;
    t_ent            e;

    always_comb begin
        n_state = r_state;  n_i = r_i;  n_j = r_j;  n_total = r_total;
        n_addr = r_addr;    n_num = r_num;  n_thr = r_thr;  n_delay = r_delay;
        n_dropped = r_dropped;  n_head = r_head;  n_more = r_more;
        n_ov = r_ov;  n_op = r_op;  n_prev = r_prev;  n_cur = r_cur;  n_out = r_out;
        w_we = 1'b0;  w_wa = r_addr;  w_wd = r_rd;
        do_place = 1'b0;  do_remove = 1'b0;  do_rfin = 1'b0;  do_emit = 1'b0;
        place_k = r_i;  rem_k = r_i;  emit_st = ST_DONE;
        e = r_rd;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_op  = i_s_tuser;
                    n_num = s_pn;
                    unique case (i_s_tuser)
                        OP_INSERT: begin
                            n_i = '0;
                            if (r_total == '0) begin
                                n_state = S_PUT;
                            end else begin
                                n_addr  = '0;
                                n_state = S_INS_RD;
                            end
                        end
                        OP_PRUNE: begin
                            n_thr = s_ib;
                            if (r_total == '0) begin
                                do_emit = 1'b1;  emit_st = ST_DONE;
                            end else begin
                                n_addr  = '0;
                                n_state = S_PR_RD;
                            end
                        end
                        OP_LOSS: begin
                            if (r_total == '0 || s_pn <= r_thr) begin
                                do_emit = 1'b1;  emit_st = ST_NOT_LOST;
                            end else begin
                                n_addr  = AW'(r_total - TW'(1));
                                n_state = S_LS_TRD;
                            end
                        end
                        OP_GEN: begin
                            if (r_dropped || r_total == '0 ||
                                (!s_req && (s_alarm == '0 || s_now < s_alarm))) begin
                                do_emit = 1'b1;  emit_st = ST_NO_ACK;
                            end else begin
                                n_i     = r_total - TW'(1);
                                n_addr  = AW'(r_total - TW'(1));
                                n_head  = 1'b1;
                                n_delay = (s_now >= s_seen) ? s_now - s_seen : '0;
                                n_state = S_GEN_RD;
                            end
                        end
                        OP_DROP: begin
                            n_total   = '0;
                            n_dropped = 1'b1;
                            do_emit   = 1'b1;  emit_st = ST_DONE;
                        end
                        default: begin
                            do_emit = 1'b1;  emit_st = ST_DONE;
                        end
                    endcase
                end
            end
            S_INS_RD: n_state = S_INS_EV;
            S_INS_EV: begin
                if (e.lo <= r_num && r_num <= e.hi) begin
                    do_emit = 1'b1;  emit_st = ST_DUP;
                end else if (e.hi != MASK && e.hi + NB'(1) == r_num) begin
                    // extend upward, then check the next range for contact
                    w_we  = 1'b1;
                    w_wa  = AW'(r_i);
                    w_wd  = '{lo: e.lo, hi: r_num};
                    n_cur = '{lo: e.lo, hi: r_num};
                    if (r_i + TW'(1) < r_total) begin
                        n_addr  = AW'(r_i + TW'(1));
                        n_state = S_MRG_RD;
                    end else begin
                        do_emit = 1'b1;  emit_st = ST_INSERTED;
                    end
                end else if (e.lo != '0 && e.lo - NB'(1) == r_num) begin
                    w_we = 1'b1;
                    if (r_i != '0 && r_prev.hi + NB'(1) == r_num) begin
                        // closes the gap to the lower range: fold into it
                        w_wa      = AW'(r_i - TW'(1));
                        w_wd      = '{lo: r_prev.lo, hi: e.hi};
                        do_remove = 1'b1;
                        rem_k     = r_i;
                    end else begin
                        w_wa    = AW'(r_i);
                        w_wd    = '{lo: r_num, hi: e.hi};
                        do_emit = 1'b1;  emit_st = ST_INSERTED;
                    end
                end else if (r_num < e.lo) begin
                    do_place = 1'b1;
                    place_k  = r_i;
                end else begin
                    n_prev = e;
                    n_i    = r_i + TW'(1);
                    if (r_i + TW'(1) < r_total) begin
                        n_addr  = AW'(r_i + TW'(1));
                        n_state = S_INS_RD;
                    end else begin
                        do_place = 1'b1;
                        place_k  = r_i + TW'(1);
                    end
                end
            end
            S_MRG_RD: n_state = S_MRG_EV;
            S_MRG_EV: begin
                if (e.lo - NB'(1) == r_num) begin
                    w_we      = 1'b1;
                    w_wa      = AW'(r_i);
                    w_wd      = '{lo: r_cur.lo, hi: e.hi};
                    do_remove = 1'b1;
                    rem_k     = r_i + TW'(1);
                end else begin
                    do_emit = 1'b1;  emit_st = ST_INSERTED;
                end
            end
            S_SHD_RD: n_state = S_SHD_WR;
            S_SHD_WR: begin
                w_we = 1'b1;
                w_wa = AW'(r_j);
                w_wd = r_rd;
                n_j  = r_j + TW'(1);
                if (r_j + TW'(2) < r_total) begin
                    n_addr  = AW'(r_j + TW'(2));
                    n_state = S_SHD_RD;
                end else begin
                    do_rfin = 1'b1;
                end
            end
            S_SHU_RD: n_state = S_SHU_WR;
            S_SHU_WR: begin
                w_we = 1'b1;
                w_wa = AW'(r_j);
                w_wd = r_rd;
                n_j  = r_j - TW'(1);
                if (r_j - TW'(1) > r_i) begin
                    n_addr  = AW'(r_j - TW'(2));
                    n_state = S_SHU_RD;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_wa    = AW'(r_i);
                w_wd    = '{lo: r_num, hi: r_num};
                n_total = r_total + TW'(1);
                do_emit = 1'b1;  emit_st = ST_INSERTED;
            end
            S_PR_RD: n_state = S_PR_EV;
            S_PR_EV: begin
                if (r_thr <= e.lo) begin
                    do_emit = 1'b1;  emit_st = ST_DONE;
                end else if (r_thr > e.hi) begin
                    do_remove = 1'b1;
                    rem_k     = '0;
                end else begin
                    w_we    = 1'b1;
                    w_wa    = '0;
                    w_wd    = '{lo: r_thr, hi: e.hi};
                    do_emit = 1'b1;  emit_st = ST_DONE;
                end
            end
            S_LS_TRD: n_state = S_LS_TEV;
            S_LS_TEV: begin
                if (r_num >= e.lo) begin
                    do_emit = 1'b1;  emit_st = ST_NOT_LOST;
                end else begin
                    n_i     = '0;
                    n_addr  = '0;
                    n_state = S_LS_RD;
                end
            end
            S_LS_RD: n_state = S_LS_EV;
            S_LS_EV: begin
                if (r_num < e.lo) begin
                    do_emit = 1'b1;  emit_st = ST_LOST;
                end else if (r_num <= e.hi || r_i + TW'(1) >= r_total) begin
                    do_emit = 1'b1;  emit_st = ST_NOT_LOST;
                end else begin
                    n_i     = r_i + TW'(1);
                    n_addr  = AW'(r_i + TW'(1));
                    n_state = S_LS_RD;
                end
            end
            S_GEN_RD: n_state = S_GEN_EV;
            S_GEN_EV: begin
                n_prev = e;
                n_ov   = 1'b1;
                n_out  = '0;
                n_out.len  = e.hi - e.lo;
                n_out.last = (r_i == '0);
                if (r_head) begin
                    n_out.status = ST_ACK_HEAD;
                    n_out.la     = e.hi;
                    n_out.dly    = r_delay;
                    n_out.ext    = EXT_W'(r_i);
                end else begin
                    n_out.status = ST_ACK_RNG;
                    n_out.gap    = r_prev.lo - e.hi - NB'(2);
                end
                n_head  = 1'b0;
                n_more  = (r_i != '0);
                n_i     = (r_i != '0) ? r_i - TW'(1) : r_i;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_m_tready) begin
                    n_ov = 1'b0;
                    if (r_more) begin
                        n_addr  = AW'(r_i);
                        n_state = S_GEN_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // open a slot at place_k by moving the upper entries up one, or report full if no entry is free
        if (do_place) begin
            if (r_total >= TW'(MAX_RANGES)) begin
                do_emit = 1'b1;  emit_st = ST_FULL;
            end else begin
                n_i = place_k;
                n_j = r_total;
                if (r_total > place_k) begin
                    n_addr  = AW'(r_total - TW'(1));
                    n_state = S_SHU_RD;
                end else begin
                    n_state = S_PUT;
                end
            end
        end

        // close the slot at rem_k by moving the upper entries down one
        if (do_remove) begin
            n_j = rem_k;
            if (rem_k + TW'(1) < r_total) begin
                n_addr  = AW'(rem_k + TW'(1));
                n_state = S_SHD_RD;
            end else begin
                do_rfin = 1'b1;
            end
        end

        if (do_rfin) begin
            n_total = r_total - TW'(1);
            if (r_op == OP_PRUNE && r_total != TW'(1)) begin
                n_addr  = '0;
                n_state = S_PR_RD;
            end else begin
                do_emit = 1'b1;
                emit_st = (r_op == OP_PRUNE) ? ST_DONE : ST_INSERTED;
            end
        end

        if (do_emit) begin
            n_out   = f_single(emit_st);
            n_ov    = 1'b1;
            n_more  = 1'b0;
            n_state = S_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_addr  <= n_addr;
        r_num   <= n_num;
        r_delay <= n_delay;
        r_op    <= n_op;
        r_prev  <= n_prev;
        r_cur   <= n_cur;
        r_out   <= n_out;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_thr     <= '0;
            r_dropped <= 1'b0;
            r_head    <= 1'b0;
            r_more    <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_thr     <= n_thr;
            r_dropped <= n_dropped;
            r_head    <= n_head;
            r_more    <= n_more;
            r_ov      <= n_ov;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_out.status;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = OUTW'({r_out.ext, r_out.dly, r_out.gap, r_out.len, r_out.la});

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TW'(MAX_RANGES))
        else $error("range count above table size");

    a_full_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ST_FULL |-> r_total == TW'(MAX_RANGES))
        else $error("full reported with free entries");

    a_drop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == OP_DROP |=> r_total == '0 && r_dropped)
        else $error("drop did not empty the table");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !o_m_tvalid)
        else $error("input taken while a result is pending");

    // head is the last item only when the table holds a single range
    a_head_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ST_ACK_HEAD |-> o_m_tlast == (r_total == TW'(1)))
        else $error("ack head last flag disagrees with range count");

endmodule
`default_nettype wire

[bench/tb_top.sv]
// testbench for the ack range tracker: table of directed items, random traffic, scoreboard
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import art_pkg::*;

    localparam int NB = NUMBER_BITS_DEF;
    localparam int NR = MAX_RANGES_DEF;
    localparam int IN_W = ((5*NB+1+7)/8)*8;
    localparam int OUT_W = ((4*NB+EXT_W+7)/8)*8;
    localparam logic [NB-1:0] NUM_MAX = '1;
    localparam int RANDOM_ITEMS = 120;
    localparam int CYCLE_LIMIT = 1000000;

    // one input item, fields by name
    typedef struct {
        logic [OP_W-1:0] op;
        logic [NB-1:0] num;
        logic [NB-1:0] thr;
        logic [NB-1:0] now;
        logic req;
        logic [NB-1:0] alarm;
        logic [NB-1:0] seen;
    } tracker_item_t;

    // one result item
    typedef struct packed {
        logic [ST_W-1:0] st;
        logic [NB-1:0] la;
        logic [NB-1:0] len;
        logic [NB-1:0] gap;
        logic [NB-1:0] dly;
        logic [EXT_W-1:0] extra;
        logic last;
    } ack_result_t;

    // directed row: item plus a status typed in by hand where obvious
    typedef struct {
        tracker_item_t item;
        bit fixed;
        logic [ST_W-1:0] fixed_st;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [IN_W-1:0] i_s_tdata = '0;
    logic [OP_W-1:0] i_s_tuser = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;
    logic [ST_W-1:0] o_m_tuser;
    logic o_m_tlast;

    ack_range_tracker uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser),
        .o_m_tlast(o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the range table kept by the predictor
    logic [NB-1:0] shadow_low [NR];
    logic [NB-1:0] shadow_high [NR];
    int shadow_count = 0;
    logic [NB-1:0] shadow_thr = '0;
    bit shadow_dropped = 1'b0;

    ack_result_t expected_results [$];
    int fail_count = 0;
    bit no_idle = 1'b0;
    stim_row_t rows [$];
    int cycle_count = 0;

    // ---------------- predictor ----------------

    function automatic void delete_range(int idx);
        for (int j = idx; j + 1 < shadow_count; j++) begin
            shadow_low[j] = shadow_low[j+1];
            shadow_high[j] = shadow_high[j+1];
        end
        shadow_count--;
    endfunction

    function automatic logic [ST_W-1:0] open_range(int idx, logic [NB-1:0] num);
        if (shadow_count >= NR) return ST_FULL;
        for (int j = shadow_count; j > idx; j--) begin
            shadow_low[j] = shadow_low[j-1];
            shadow_high[j] = shadow_high[j-1];
        end
        shadow_low[idx] = num;
        shadow_high[idx] = num;
        shadow_count++;
        return ST_INSERTED;
    endfunction

    function automatic logic [ST_W-1:0] record_packet(logic [NB-1:0] num);
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_low[i] <= num && num <= shadow_high[i]) return ST_DUP;
            // grow upward, then merge with the next range if it now touches
            if (shadow_high[i] < NUM_MAX && shadow_high[i] + 1'b1 == num) begin
                shadow_high[i] = num;
                if (i + 1 < shadow_count && shadow_low[i+1] - 1'b1 == num) begin
                    shadow_high[i] = shadow_high[i+1];
                    delete_range(i + 1);
                end
                return ST_INSERTED;
            end
            // grow downward, then merge with the previous range
            if (shadow_low[i] > 0 && shadow_low[i] - 1'b1 == num) begin
                shadow_low[i] = num;
                if (i > 0 && shadow_high[i-1] + 1'b1 == num) begin
                    shadow_high[i-1] = shadow_high[i];
                    delete_range(i);
                end
                return ST_INSERTED;
            end
            if (num < shadow_low[i]) return open_range(i, num);
        end
        return open_range(shadow_count, num);
    endfunction

    function automatic void prune_below(logic [NB-1:0] thr);
        shadow_thr = thr;
        while (shadow_count > 0) begin
            if (thr <= shadow_low[0]) return;
            if (thr > shadow_high[0]) delete_range(0);
            else begin
                shadow_low[0] = thr;
                return;
            end
        end
    endfunction

    function automatic logic [ST_W-1:0] check_loss(logic [NB-1:0] num);
        if (shadow_count == 0 || num <= shadow_thr || num >= shadow_low[shadow_count-1])
            return ST_NOT_LOST;
        for (int i = 0; i < shadow_count; i++) begin
            if (num < shadow_low[i]) return ST_LOST;
            if (num <= shadow_high[i]) return ST_NOT_LOST;
        end
        return ST_NOT_LOST;
    endfunction

    function automatic ack_result_t single_result(logic [ST_W-1:0] st);
        ack_result_t r;
        r = '{st: st, la: '0, len: '0, gap: '0, dly: '0, extra: '0, last: 1'b1};
        return r;
    endfunction

    // works out the result items of one accepted item and queues them
    function automatic void predict_ack_results(tracker_item_t it);
        ack_result_t r;
        int top;
        logic [NB-1:0] smallest;
        case (it.op)
            OP_INSERT: expected_results.push_back(single_result(record_packet(it.num)));
            OP_PRUNE: begin
                prune_below(it.thr);
                expected_results.push_back(single_result(ST_DONE));
            end
            OP_LOSS: expected_results.push_back(single_result(check_loss(it.num)));
            OP_GEN: begin
                if (shadow_dropped || shadow_count == 0 ||
                    (!it.req && (it.alarm == 0 || it.now < it.alarm))) begin
                    expected_results.push_back(single_result(ST_NO_ACK));
                end else begin
                    top = shadow_count - 1;
                    r = single_result(ST_ACK_HEAD);
                    r.la = shadow_high[top];
                    r.len = shadow_high[top] - shadow_low[top];
                    r.dly = (it.now >= it.seen) ? it.now - it.seen : '0;
                    r.extra = top[EXT_W-1:0];
                    r.last = (top == 0);
                    expected_results.push_back(r);
                    smallest = shadow_low[top];
                    for (int i = top - 1; i >= 0; i--) begin
                        r = single_result(ST_ACK_RNG);
                        r.len = shadow_high[i] - shadow_low[i];
                        r.gap = smallest - shadow_high[i] - NB'(2);
                        r.last = (i == 0);
                        expected_results.push_back(r);
                        smallest = shadow_low[i];
                    end
                end
            end
            OP_DROP: begin
                shadow_count = 0;
                shadow_dropped = 1'b1;
                expected_results.push_back(single_result(ST_DONE));
            end
            default: expected_results.push_back(single_result(ST_DONE));
        endcase
    endfunction

    // ---------------- helpers ----------------

    function automatic logic [NB-1:0] rand_num();
        return NB'({$urandom, $urandom});
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 9);
        if (r < 5) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic tracker_item_t noise_item(logic [OP_W-1:0] op);
        tracker_item_t it;
        it = '{op: op, num: rand_num(), thr: rand_num(), now: rand_num(),
               req: 1'($urandom_range(0, 1)), alarm: rand_num(), seen: rand_num()};
        return it;
    endfunction

    task automatic add_row(logic [OP_W-1:0] op, logic [NB-1:0] num, logic [NB-1:0] thr,
                           logic [NB-1:0] now, logic req, logic [NB-1:0] alarm,
                           logic [NB-1:0] seen, bit fixed, logic [ST_W-1:0] st);
        stim_row_t row;
        row.item = '{op: op, num: num, thr: thr, now: now, req: req, alarm: alarm, seen: seen};
        row.fixed = fixed;
        row.fixed_st = st;
        rows.push_back(row);
    endtask

    // drives one item and waits for the handshake; valid stays up across back-to-back items
    task automatic send_item(tracker_item_t it, bit fixed = 1'b0,
                             logic [ST_W-1:0] fixed_st = ST_DONE);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {1'b0, it.seen, it.alarm, it.req, it.now, it.thr, it.num};
        i_s_tuser <= it.op;
        do @(posedge i_clk); while (!o_s_tready);
        predict_ack_results(it);
        if (fixed) expected_results[expected_results.size()-1].st = fixed_st;
    endtask

    task automatic idle_sender();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ---------------- result checking ----------------

    int stall_left = 0;

    always @(posedge i_clk) begin
        ack_result_t got;
        ack_result_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.la = o_m_tdata[NB-1:0];
            got.len = o_m_tdata[2*NB-1:NB];
            got.gap = o_m_tdata[3*NB-1:2*NB];
            got.dly = o_m_tdata[4*NB-1:3*NB];
            got.extra = o_m_tdata[4*NB+EXT_W-1:4*NB];
            got.st = o_m_tuser;
            got.last = o_m_tlast;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected item st=%0d la=%h len=%h", $time,
                         got.st, got.la, got.len);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (got != want) begin
                    $display("%0t: mismatch expected st=%0d la=%h len=%h gap=%h dly=%h x=%0d l=%b",
                             $time, want.st, want.la, want.len, want.gap, want.dly,
                             want.extra, want.last);
                    $display("%0t:          actual st=%0d la=%h len=%h gap=%h dly=%h x=%0d l=%b",
                             $time, got.st, got.la, got.len, got.gap, got.dly,
                             got.extra, got.last);
                    fail_count++;
                end
            end
        end
        // sink stalls
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = idle_len();
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    initial begin
        tracker_item_t it;
        logic [NB-1:0] base;
        int n_sent;
        int head_rows;
        int pick;

        // directed part: empty table, number edges, merges, alarm cases, prune, odd opcodes
        add_row(OP_GEN, 0, 0, 100, 1, 0, 0, 1, ST_NO_ACK);
        add_row(OP_LOSS, 7, 0, 0, 0, 0, 0, 1, ST_NOT_LOST);
        add_row(OP_INSERT, 0, 0, 0, 0, 0, 0, 1, ST_INSERTED);
        add_row(OP_INSERT, 0, 0, 0, 0, 0, 0, 1, ST_DUP);
        add_row(OP_INSERT, NUM_MAX, 0, 0, 0, 0, 0, 1, ST_INSERTED);
        add_row(OP_INSERT, NUM_MAX - NB'(1), 0, 0, 0, 0, 0, 1, ST_INSERTED);
        add_row(OP_INSERT, 2, 0, 0, 0, 0, 0, 1, ST_INSERTED);
        add_row(OP_LOSS, 1, 0, 0, 0, 0, 0, 1, ST_LOST);
        add_row(OP_INSERT, 1, 0, 0, 0, 0, 0, 1, ST_INSERTED);
        add_row(OP_LOSS, 1, 0, 0, 0, 0, 0, 1, ST_NOT_LOST);
        add_row(OP_GEN, 0, 0, 100, 1, 0, 40, 0, ST_DONE);
        add_row(OP_GEN, 0, 0, 100, 0, 0, 40, 1, ST_NO_ACK);
        add_row(OP_GEN, 0, 0, 49, 0, 50, 40, 1, ST_NO_ACK);
        // alarm due exactly now, seen time after now so the delay saturates
        add_row(OP_GEN, 0, 0, 50, 0, 50, 60, 0, ST_DONE);
        add_row(OP_LOSS, NUM_MAX, 0, 0, 0, 0, 0, 1, ST_NOT_LOST);
        add_row(OP_PRUNE, 0, 1, 0, 0, 0, 0, 1, ST_DONE);
        add_row(OP_LOSS, 1, 0, 0, 0, 0, 0, 1, ST_NOT_LOST);
        add_row(3'd5, NUM_MAX, NUM_MAX, NUM_MAX, 1, NUM_MAX, NUM_MAX, 1, ST_DONE);
        add_row(3'd6, 0, 0, 0, 0, 0, 0, 1, ST_DONE);
        add_row(3'd7, NUM_MAX, NUM_MAX, NUM_MAX, 1, NUM_MAX, NUM_MAX, 1, ST_DONE);
        add_row(OP_GEN, NUM_MAX, NUM_MAX, NUM_MAX, 1, NUM_MAX, NUM_MAX, 0, ST_DONE);
        add_row(OP_PRUNE, 0, NUM_MAX, 0, 0, 0, 0, 1, ST_DONE);
        add_row(OP_PRUNE, 0, 0, 0, 0, 0, 0, 1, ST_DONE);
        head_rows = rows.size();
        // tail: drop clears the table and blocks generate, so it comes last
        add_row(OP_DROP, 0, 0, 0, 0, 0, 0, 1, ST_DONE);
        add_row(OP_GEN, 0, 0, 100, 1, 0, 0, 1, ST_NO_ACK);
        add_row(OP_INSERT, 5, 0, 0, 0, 0, 0, 1, ST_INSERTED);
        add_row(OP_LOSS, 3, 0, 0, 0, 0, 0, 0, ST_DONE);
        add_row(OP_GEN, 0, 0, 100, 1, 0, 0, 1, ST_NO_ACK);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < head_rows; r++)
            send_item(rows[r].item, rows[r].fixed, rows[r].fixed_st);

        // hold off until the block has drained everything
        idle_sender();
        while (expected_results.size() != 0) @(posedge i_clk);

        // random part: inserts clustered around a moving base so ranges form and merge
        base = NB'($urandom_range(0, 1000));
        n_sent = 0;
        while (n_sent < RANDOM_ITEMS) begin
            if (n_sent % 20 == 0) no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            it = noise_item(OP_INSERT);
            if (pick < 55) begin
                if ($urandom_range(0, 19) != 0) it.num = base + NB'($urandom_range(0, 60));
                send_item(it);
                n_sent++;
            end else if (pick < 68) begin
                it.op = OP_GEN;
                it.now = NB'({$urandom_range(0, 3), $urandom});
                it.seen = NB'({$urandom_range(0, 3), $urandom});
                case ($urandom_range(0, 2))
                    0: it.alarm = '0;
                    1: it.alarm = it.now - NB'($urandom_range(0, 5));
                    default: it.alarm = it.now + NB'($urandom_range(0, 5));
                endcase
                send_item(it);
                n_sent++;
            end else if (pick < 80) begin
                it.op = OP_LOSS;
                it.num = base + NB'($urandom_range(0, 70));
                send_item(it);
                n_sent++;
            end else if (pick < 86) begin
                it.op = OP_PRUNE;
                it.thr = base + NB'($urandom_range(0, 30));
                send_item(it);
                n_sent++;
            end else if (pick < 90) begin
                it.op = OP_W'($urandom_range(5, 7));
                send_item(it);
                n_sent++;
            end else if (pick < 93) begin
                // isolated numbers until the table overflows, then clear them out
                base = NB'({$urandom_range(0, 255), $urandom});
                for (int k = 0; k < NR + 2; k++) begin
                    it = noise_item(OP_INSERT);
                    it.num = base + NB'(2 * k);
                    send_item(it);
                end
                it = noise_item(OP_PRUNE);
                it.thr = base + NB'(2 * NR + 8);
                send_item(it);
                base = base + NB'(2 * NR + 8);
                n_sent += NR + 3;
            end else begin
                base = ($urandom_range(0, 3) == 0) ? NUM_MAX - NB'(40) : rand_num();
            end
        end
        no_idle = 1'b0;

        for (int r = head_rows; r < rows.size(); r++)
            send_item(rows[r].item, rows[r].fixed, rows[r].fixed_st);
        idle_sender();

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
